// ----- hdl/dash_indicator_byte_generator_macros.svh -----
// Assertion macros for the dash indicator byte generator.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef DASH_INDICATOR_BYTE_GENERATOR_MACROS_SVH
`define DASH_INDICATOR_BYTE_GENERATOR_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DIBG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dash indicator assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define DIBG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dash indicator assertion failed");

`endif

// ----- hdl/dibg_pkg.sv -----
// Shared types, constants and the code table of the dash indicator byte generator.
// No dependencies.
package dibg_pkg;

  localparam int ShiftStagesDefault = 3;
  localparam int FlashSlicesDefault = 8;
  localparam int DivWidth           = 16;

  localparam logic [7:0] LampOnTime  = 8'd10;
  localparam logic [7:0] LampOffTime = 8'd50;
  localparam logic [7:0] PatStabOff  = 8'hE0;
  localparam logic [7:0] PatStabOn   = 8'h18;

  typedef enum logic [7:0] {
    REG_LAMP_TEST_TIME      = 8'd0,
    REG_MODE_FLASH_DURATION = 8'd1,
    REG_MODE_FLASH_SLICE    = 8'd2,
    REG_BLANK_MASK          = 8'd3,
    REG_SHIFT_THRESHOLDS    = 8'd4,
    REG_STAGE_ONE_PATTERNS  = 8'd5,
    REG_STAGE_TWO_PATTERNS  = 8'd6,
    REG_STAGE_THREE_PATTERNS = 8'd7
  } reg_index_t;

  typedef struct packed {
    logic        tick_10hz;
    logic [15:0] engine_speed;
    logic        stability_off;
    logic [15:0] ignition_age;
    logic [15:0] mode_flash_timer;
    logic [2:0]  new_mode;
    logic [2:0]  gear_index;
    logic        intervention_active;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] dash_byte_zero;
    logic [7:0] dash_byte_one;
  } out_payload_t;

  // Status handed from the serial divider to the top level.
  typedef struct packed {
    logic done;
    logic q_odd;
  } div_result_t;

  function automatic logic [7:0] code_byte(input logic [2:0] idx);
    logic [7:0] code;
    case (idx)
      3'd0:    code = 8'h00;
      3'd1:    code = 8'h20;
      3'd2:    code = 8'h40;
      3'd3:    code = 8'h60;
      3'd4:    code = 8'h80;
      3'd5:    code = 8'hA0;
      3'd6:    code = 8'hC0;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/dash_indicator_byte_generator.sv -----
// Top level of the dash indicator byte generator: registers, lamp logic, output stage.
// Depends on dibg_pkg, dibg_div and dash_indicator_byte_generator_macros.svh.
//
// One request in gives one result of two dash bytes. A new request is taken only once
// the previous result has been loaded into the output register; that wait covers the
// 16-step radix-2 divider that works out the parity of the mode flash phase, one
// quotient bit per cycle. Slice counter, lamp timer and byte zero are settled in the
// accept cycle. A finished result holds in the output register until taken, and the
// block holds the next result until then.
`include "dash_indicator_byte_generator_macros.svh"

module dash_indicator_byte_generator #(
  parameter int SHIFT_STAGES = dibg_pkg::ShiftStagesDefault,
  parameter int FLASH_SLICES = dibg_pkg::FlashSlicesDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dibg_pkg::in_payload_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dibg_pkg::out_payload_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [63:0]            cfg_data
);

  localparam logic [2:0] LastSlice = 3'(FLASH_SLICES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] lamp_test_time_r;
  logic [15:0] mode_flash_duration_r;
  logic [15:0] mode_flash_slice_r;
  logic [7:0]  blank_mask_r;
  logic [47:0] shift_thresholds_r;
  logic [63:0] stage_one_r;
  logic [63:0] stage_two_r;
  logic [63:0] stage_three_r;

  logic [2:0]  flash_slice_r, flash_slice_nxt;
  logic [7:0]  lamp_timer_r, lamp_timer_nxt;
  logic        prev_off_r;

  logic [7:0]  byte_zero_r, byte_zero_nxt;
  logic [7:0]  gear_byte_r, gear_byte_nxt;
  logic [7:0]  mode_byte_r;
  logic        mode_active_r;

  logic        out_valid_r;
  dibg_pkg::out_payload_t out_data_r;

  logic        in_acc;
  logic        out_load;
  logic [1:0]  stage_sel;
  logic        stage_run;
  logic [63:0] stage_pats;
  logic [15:0] div_dividend;
  logic [2:0]  mode_idx;
  dibg_pkg::div_result_t div_res;

  assign in_ready  = state_r == ST_IDLE;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_test_time_r      <= 16'd10;
      mode_flash_duration_r <= 16'd0;
      mode_flash_slice_r    <= 16'd1;
      blank_mask_r          <= 8'd0;
      shift_thresholds_r    <= '1;
      stage_one_r           <= '0;
      stage_two_r           <= '0;
      stage_three_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dibg_pkg::REG_LAMP_TEST_TIME:       lamp_test_time_r      <= cfg_data[15:0];
        dibg_pkg::REG_MODE_FLASH_DURATION:  mode_flash_duration_r <= cfg_data[15:0];
        dibg_pkg::REG_MODE_FLASH_SLICE:     mode_flash_slice_r    <= cfg_data[15:0];
        dibg_pkg::REG_BLANK_MASK:           blank_mask_r          <= cfg_data[7:0];
        dibg_pkg::REG_SHIFT_THRESHOLDS:     shift_thresholds_r    <= cfg_data[47:0];
        dibg_pkg::REG_STAGE_ONE_PATTERNS:   stage_one_r           <= cfg_data;
        dibg_pkg::REG_STAGE_TWO_PATTERNS:   stage_two_r           <= cfg_data;
        dibg_pkg::REG_STAGE_THREE_PATTERNS: stage_three_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slice counter first, then the lamp timer, both from the incoming request.
  always_comb begin
    flash_slice_nxt = flash_slice_r;
    if (in_data.tick_10hz) begin
      flash_slice_nxt = (flash_slice_r == LastSlice) ? 3'd0 : flash_slice_r + 3'd1;
    end
    if (in_data.ignition_age < lamp_test_time_r) begin
      lamp_timer_nxt = 8'd1;
    end else if (prev_off_r && !in_data.stability_off) begin
      lamp_timer_nxt = dibg_pkg::LampOnTime;
    end else if (!prev_off_r && in_data.stability_off) begin
      lamp_timer_nxt = dibg_pkg::LampOffTime;
    end else if (in_data.tick_10hz && lamp_timer_r != 8'd0) begin
      lamp_timer_nxt = lamp_timer_r - 8'd1;
    end else begin
      lamp_timer_nxt = lamp_timer_r;
    end
  end

  // Highest stage reached: scan stops at the first threshold above the rpm.
  always_comb begin
    stage_sel = 2'd0;
    stage_run = 1'b1;
    for (int k = 0; k < SHIFT_STAGES; k++) begin
      if (stage_run && in_data.engine_speed >= shift_thresholds_r[16*k +: 16]) begin
        stage_sel = 2'(k + 1);
      end else begin
        stage_run = 1'b0;
      end
    end
  end

  always_comb begin
    case (stage_sel)
      2'd1:    stage_pats = stage_one_r;
      2'd2:    stage_pats = stage_two_r;
      2'd3:    stage_pats = stage_three_r;
      default: stage_pats = '0;
    endcase
    if (lamp_timer_nxt != 8'd0) begin
      byte_zero_nxt = in_data.stability_off ? dibg_pkg::PatStabOff : dibg_pkg::PatStabOn;
    end else begin
      byte_zero_nxt = stage_pats[8*flash_slice_nxt +: 8];
    end
    gear_byte_nxt = dibg_pkg::code_byte(in_data.gear_index);
    if (in_data.intervention_active && blank_mask_r[flash_slice_nxt]) begin
      gear_byte_nxt = 8'h00;
    end
  end

  assign div_dividend = (mode_flash_duration_r > in_data.mode_flash_timer)
                      ? mode_flash_duration_r - in_data.mode_flash_timer : 16'd0;
  assign mode_idx     = (in_data.new_mode == 3'd7) ? 3'd7 : in_data.new_mode + 3'd1;

  dibg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (div_dividend),
    .divisor  (mode_flash_slice_r),
    .result   (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)       state_nxt = ST_DIV;
      ST_DIV:  if (div_res.done) state_nxt = ST_DONE;
      ST_DONE: if (out_load)     state_nxt = ST_IDLE;
      default:                   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      flash_slice_r <= 3'd0;
      lamp_timer_r  <= 8'd0;
      prev_off_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        flash_slice_r <= flash_slice_nxt;
        lamp_timer_r  <= lamp_timer_nxt;
        prev_off_r    <= in_data.stability_off;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_zero_r   <= byte_zero_nxt;
      gear_byte_r   <= gear_byte_nxt;
      mode_byte_r   <= dibg_pkg::code_byte(mode_idx);
      mode_active_r <= in_data.mode_flash_timer != 16'd0;
    end
    if (out_load) begin
      out_data_r.dash_byte_zero <= byte_zero_r;
      if (mode_active_r) begin
        out_data_r.dash_byte_one <= div_res.q_odd ? mode_byte_r : dibg_pkg::code_byte(3'd0);
      end else begin
        out_data_r.dash_byte_one <= gear_byte_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DIBG_ASSERT_NEXT(a_accept_starts_div, in_acc, state_r == ST_DIV)
  `DIBG_ASSERT_SAME(a_div_done_in_div, div_res.done, state_r == ST_DIV)
  `DIBG_ASSERT_SAME(a_lamp_timer_bound, 1'b1, lamp_timer_r <= dibg_pkg::LampOffTime)
  `DIBG_ASSERT_SAME(a_slice_bound, 1'b1, flash_slice_r <= LastSlice)

endmodule

// ----- hdl/dibg_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle; reports quotient parity.
// Depends on dibg_pkg.
module dibg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dibg_pkg::DivWidth-1:0]  dividend,
  input  logic [dibg_pkg::DivWidth-1:0]  divisor,
  output dibg_pkg::div_result_t          result
);

  localparam int W  = dibg_pkg::DivWidth;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LastStep = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          q_odd_r, q_odd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // A zero divisor passes every trial, so the quotient comes out all ones.
  assign trial = {rem_r, dvd_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    q_odd_nxt = q_odd_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LastStep) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        q_odd_nxt = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_odd_r <= q_odd_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
  end

  assign result.done  = done_r;
  assign result.q_odd = q_odd_r;

endmodule
